/* src/track_first_station_predictor_assert.svh */
// Assertion macros used by the station predictor top level.
`ifndef TRACK_FIRST_STATION_PREDICTOR_ASSERT_SVH
`define TRACK_FIRST_STATION_PREDICTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TFSP_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TFSP_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* src/tfsp_pkg.sv */
package tfsp_pkg;

    localparam int MOM_W            = 21;
    localparam int VTX_XY_W         = 15;
    localparam int VTX_Z_W          = 16;
    localparam int RAD_W            = 12;
    localparam int Z_W              = 11;
    localparam int BASE_W           = 15;
    localparam int PROD_W           = 38;
    localparam int MAG_W            = 32;
    localparam int LIM_W            = 64;
    localparam int TABLE_SIZE       = 42;
    localparam int NUM_STATIONS_DEF = 42;
    localparam int CFG_IDX_W        = 1;

    localparam logic [RAD_W-1:0] INNER_RESET = 12'd131;
    localparam logic [RAD_W-1:0] OUTER_RESET = 12'd670;

    localparam logic signed [Z_W-1:0] NOT_FOUND_Z = -11'sd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INNER,
        REG_OUTER
    } cfg_reg_t;

    localparam logic signed [Z_W-1:0] STATION_MM [TABLE_SIZE] = '{
        -11'sd175, -11'sd160, -11'sd145, -11'sd130, -11'sd115, -11'sd100,
        -11'sd85,  -11'sd70,  -11'sd55,  -11'sd40,  -11'sd25,  -11'sd10,
        11'sd5,    11'sd20,   11'sd35,   11'sd50,   11'sd65,   11'sd80,
        11'sd95,   11'sd110,  11'sd125,  11'sd140,  11'sd155,  11'sd170,
        11'sd185,  11'sd200,  11'sd215,  11'sd230,  11'sd245,  11'sd260,
        11'sd275,  11'sd290,  11'sd435,  11'sd450,  11'sd585,  11'sd600,
        11'sd635,  11'sd650,  11'sd685,  11'sd700,  11'sd735,  11'sd750
    };

    typedef struct packed {
        logic signed [MOM_W-1:0]   px;
        logic signed [MOM_W-1:0]   py;
        logic signed [VTX_Z_W-1:0] vz;
    } tfsp_s1_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] x0;
        logic signed [PROD_W-1:0] y0;
    } tfsp_s2_t;

    typedef struct packed {
        logic [LIM_W-1:0] in_lim;
        logic [LIM_W-1:0] out_lim;
    } tfsp_lim_t;

endpackage

/* src/tfsp_if.sv */
interface tfsp_track_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [tfsp_pkg::MOM_W-1:0]     mom_x;
    logic signed [tfsp_pkg::MOM_W-1:0]     mom_y;
    logic signed [tfsp_pkg::MOM_W-1:0]     mom_z;
    logic signed [tfsp_pkg::VTX_XY_W-1:0]  vertex_x;
    logic signed [tfsp_pkg::VTX_XY_W-1:0]  vertex_y;
    logic signed [tfsp_pkg::VTX_Z_W-1:0]   vertex_z;

    modport source (
        output valid, mom_x, mom_y, mom_z, vertex_x, vertex_y, vertex_z,
        input  ready
    );
    modport sink (
        input  valid, mom_x, mom_y, mom_z, vertex_x, vertex_y, vertex_z,
        output ready
    );
endinterface

interface tfsp_result_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic signed [tfsp_pkg::Z_W-1:0]  station_z;

    modport source (
        output valid, found, station_z,
        input  ready
    );
    modport sink (
        input  valid, found, station_z,
        output ready
    );
endinterface

/* src/tfsp_front.sv */
module tfsp_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    tfsp_track_if.sink                     track,
    input  logic [tfsp_pkg::RAD_W-1:0]     inner_radius,
    input  logic [tfsp_pkg::RAD_W-1:0]     outer_radius,
    output tfsp_pkg::tfsp_s1_t             s1,
    output tfsp_pkg::tfsp_s2_t             s2,
    output tfsp_pkg::tfsp_lim_t            lim,
    output logic                           valid5
);
    import tfsp_pkg::*;

    localparam int STAGES = 5;
    localparam int VP_W   = VTX_XY_W + MOM_W;
    localparam int PV_W   = MOM_W + VTX_Z_W;

    logic [STAGES-1:0]        valid_reg, valid_next;
    logic signed [VP_W-1:0]   vxpz_reg, vxpz_next, vypz_reg, vypz_next;
    logic signed [PV_W-1:0]   pxvz_reg, pxvz_next, pyvz_reg, pyvz_next;
    logic [MOM_W-1:0]         apz;
    logic [MAG_W-1:0]         rin_reg, rin_next, rout_reg, rout_next;
    tfsp_s1_t                 s1_reg, s1_next;
    tfsp_s2_t                 s2_reg, s2_next;
    tfsp_lim_t                lim2_reg, lim2_next, lim3_reg, lim4_reg;

    assign track.ready = en;

    always_comb
    begin
        valid_next = {valid_reg[STAGES-2:0], track.valid};

        apz = track.mom_z[MOM_W-1] ? MOM_W'(-track.mom_z) : MOM_W'(track.mom_z);

        vxpz_next = VP_W'(track.vertex_x) * VP_W'(track.mom_z);
        vypz_next = VP_W'(track.vertex_y) * VP_W'(track.mom_z);
        pxvz_next = PV_W'(track.mom_x) * PV_W'(track.vertex_z);
        pyvz_next = PV_W'(track.mom_y) * PV_W'(track.vertex_z);
        rin_next  = MAG_W'(inner_radius) * MAG_W'(apz);
        rout_next = MAG_W'(outer_radius) * MAG_W'(apz);

        s1_next.px = track.mom_x;
        s1_next.py = track.mom_y;
        s1_next.vz = track.vertex_z;

        s2_next.x0 = PROD_W'(vxpz_reg) - PROD_W'(pxvz_reg);
        s2_next.y0 = PROD_W'(vypz_reg) - PROD_W'(pyvz_reg);

        lim2_next.in_lim  = LIM_W'(rin_reg) * LIM_W'(rin_reg);
        lim2_next.out_lim = LIM_W'(rout_reg) * LIM_W'(rout_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vxpz_reg <= vxpz_next;
            vypz_reg <= vypz_next;
            pxvz_reg <= pxvz_next;
            pyvz_reg <= pyvz_next;
            rin_reg  <= rin_next;
            rout_reg <= rout_next;
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            lim2_reg <= lim2_next;
            lim3_reg <= lim2_reg;
            lim4_reg <= lim3_reg;
        end
    end

    assign s1     = s1_reg;
    assign s2     = s2_reg;
    assign lim    = lim4_reg;
    assign valid5 = valid_reg[STAGES-1];

endmodule

/* src/tfsp_lane.sv */
module tfsp_lane #(
    parameter int LANE_IDX = 0
) (
    input  logic                  clk,
    input  logic                  en,
    input  tfsp_pkg::tfsp_s1_t    s1,
    input  tfsp_pkg::tfsp_s2_t    s2,
    input  tfsp_pkg::tfsp_lim_t   lim,
    output logic                  hit
);
    import tfsp_pkg::*;

    localparam int PC_W  = MOM_W + BASE_W;
    localparam int SUM_W = PROD_W + 1;
    localparam logic signed [BASE_W-1:0] BASE = BASE_W'(STATION_MM[LANE_IDX]) <<< 4;

    logic                     ok2_reg, ok2_next;
    logic signed [PC_W-1:0]   pcx_reg, pcx_next, pcy_reg, pcy_next;
    logic signed [SUM_W-1:0]  sumx, sumy;
    logic [SUM_W-1:0]         magx, magy;
    logic                     ok3_reg, big3_reg, big3_next;
    logic [MAG_W-1:0]         ax_reg, ax_next, ay_reg, ay_next;
    logic                     use4_reg, use4_next;
    logic [LIM_W-1:0]         sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [LIM_W:0]           r2;
    logic                     hit_reg, hit_next;

    always_comb
    begin
        ok2_next = s1.vz <= VTX_Z_W'(BASE);
        pcx_next = PC_W'(s1.px) * PC_W'(BASE);
        pcy_next = PC_W'(s1.py) * PC_W'(BASE);

        sumx      = SUM_W'(s2.x0) + SUM_W'(pcx_reg);
        sumy      = SUM_W'(s2.y0) + SUM_W'(pcy_reg);
        magx      = sumx[SUM_W-1] ? -sumx : sumx;
        magy      = sumy[SUM_W-1] ? -sumy : sumy;
        ax_next   = magx[MAG_W-1:0];
        ay_next   = magy[MAG_W-1:0];
        big3_next = (|magx[SUM_W-1:MAG_W]) || (|magy[SUM_W-1:MAG_W]);

        use4_next = ok3_reg && !big3_reg;
        sqx_next  = LIM_W'(ax_reg) * LIM_W'(ax_reg);
        sqy_next  = LIM_W'(ay_reg) * LIM_W'(ay_reg);

        r2       = (LIM_W + 1)'(sqx_reg) + (LIM_W + 1)'(sqy_reg);
        hit_next = use4_reg && (r2 > (LIM_W + 1)'(lim.in_lim))
                            && (r2 < (LIM_W + 1)'(lim.out_lim));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok2_reg  <= ok2_next;
            pcx_reg  <= pcx_next;
            pcy_reg  <= pcy_next;
            ok3_reg  <= ok2_reg;
            big3_reg <= big3_next;
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            use4_reg <= use4_next;
            sqx_reg  <= sqx_next;
            sqy_reg  <= sqy_next;
            hit_reg  <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

/* src/tfsp_select.sv */
module tfsp_select #(
    parameter int LANES = 42
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid5,
    input  logic [LANES-1:0]   hit,
    output logic               advance,
    tfsp_result_if.source      result
);
    import tfsp_pkg::*;

    logic                    out_valid_reg;
    logic                    found_reg, found_next;
    logic signed [Z_W-1:0]   station_z_reg, station_z_next;

    assign advance = !out_valid_reg || result.ready;

    // The lowest station index with a hit wins.
    always_comb
    begin
        found_next     = |hit;
        station_z_next = NOT_FOUND_Z;
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                station_z_next = STATION_MM[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= valid5;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            found_reg     <= found_next;
            station_z_reg <= station_z_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.found     = found_reg;
    assign result.station_z = station_z_reg;

endmodule

/* src/track_first_station_predictor.sv */
// Track first-station predictor. Each accepted track is extrapolated in parallel to each of the
// first LANES stations of the fixed z table (one lane per station), and the first station at or
// downstream of the vertex whose squared radius lies strictly between the inner and outer limits
// is reported; otherwise found is low and station_z is -1000. A request can be accepted on every
// clock while the result is taken, because each of the six register stages (five of arithmetic,
// whose widest step is a 32x32 multiply, and the output register) then takes new data each cycle.
// When the result is not taken, the whole pipeline holds and no request is accepted. The radius
// registers are written through the configuration port; the user must write them only while no
// request is in flight, as the block itself does not enforce this.
`include "track_first_station_predictor_assert.svh"

module track_first_station_predictor #(
    parameter int NUM_STATIONS = tfsp_pkg::NUM_STATIONS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tfsp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tfsp_pkg::RAD_W-1:0]       cfg_data,
    tfsp_track_if.sink                       track,
    tfsp_result_if.source                    result
);
    import tfsp_pkg::*;

    localparam int LANES = (NUM_STATIONS < TABLE_SIZE) ? NUM_STATIONS : TABLE_SIZE;
    localparam logic signed [Z_W-1:0] STATION_MIN = STATION_MM[0];

    logic [RAD_W-1:0]   inner_radius_reg, inner_radius_next;
    logic [RAD_W-1:0]   outer_radius_reg, outer_radius_next;
    logic               advance;
    logic               valid5;
    logic [LANES-1:0]   hit;
    tfsp_s1_t           s1;
    tfsp_s2_t           s2;
    tfsp_lim_t          lim;
    logic               cfg_inner_we;
    logic               out_none;
    logic               out_hit;

    always_comb
    begin
        inner_radius_next = inner_radius_reg;
        outer_radius_next = outer_radius_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_INNER: inner_radius_next = cfg_data;
                REG_OUTER: outer_radius_next = cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_radius_reg <= INNER_RESET;
            outer_radius_reg <= OUTER_RESET;
        end
        else
        begin
            inner_radius_reg <= inner_radius_next;
            outer_radius_reg <= outer_radius_next;
        end
    end

    tfsp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (advance),
        .track        (track),
        .inner_radius (inner_radius_reg),
        .outer_radius (outer_radius_reg),
        .s1           (s1),
        .s2           (s2),
        .lim          (lim),
        .valid5       (valid5)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        tfsp_lane #(
            .LANE_IDX (g)
        ) u_lane (
            .clk (clk),
            .en  (advance),
            .s1  (s1),
            .s2  (s2),
            .lim (lim),
            .hit (hit[g])
        );
    end

    tfsp_select #(
        .LANES (LANES)
    ) u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid5  (valid5),
        .hit     (hit),
        .advance (advance),
        .result  (result)
    );

    assign cfg_inner_we = cfg_we && (cfg_index == REG_INNER);
    assign out_none     = result.valid && !result.found;
    assign out_hit      = result.valid && result.found;

    `TFSP_ASSERT_NEXT(a_cfg_inner, clk, rst_n, cfg_inner_we, inner_radius_reg == $past(cfg_data))
    `TFSP_ASSERT_IMPLY(a_none_z, clk, rst_n, out_none, result.station_z == NOT_FOUND_Z)
    `TFSP_ASSERT_IMPLY(a_found_z, clk, rst_n, out_hit, result.station_z >= STATION_MIN)

endmodule
